/* src/rrs_pkg.sv */
// shared types, codes and constants of the rtp relay statistics router
package rrs_pkg;

	localparam int DIR_COUNT = 2;

	// verdict codes
	localparam logic [1:0] V_BAD     = 2'd0;
	localparam logic [1:0] V_UNKNOWN = 2'd1;
	localparam logic [1:0] V_CALLER  = 2'd2;
	localparam logic [1:0] V_CALLEE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_CALLER_ADDR = 2'd0;
	localparam logic [1:0] CFG_CALLEE_ADDR = 2'd1;
	localparam logic [1:0] CFG_CALLER_PORT = 2'd2;
	localparam logic [1:0] CFG_CALLEE_PORT = 2'd3;

	localparam logic [1:0]  VERSION_RTP   = 2'd2;
	localparam logic [15:0] SEQ_GAP_LIMIT = 16'd3000;
	localparam int          TS_SHIFT      = 3;
	localparam int          JIT_SHIFT     = 4;

	// per-direction statistics entry
	typedef struct packed {
		logic [31:0] packets;
		logic [31:0] lost;
		logic [15:0] prev_seq;
		logic [31:0] prev_transit;
		logic [35:0] jitter;
	} dir_state_t;

	localparam int DIR_STATE_W = $bits(dir_state_t);

endpackage

/* src/rrs_ram.sv */
// generic single write port ram with registered read
module rrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/rrs_update.sv */
// per-direction loss and jitter update of one statistics entry
module rrs_update
	import rrs_pkg::*;
(
	input  dir_state_t  old_state,
	input  logic        first,
	input  logic [15:0] seq,
	input  logic [31:0] transit,
	output dir_state_t  new_state
);

	logic [15:0] delta;
	logic [31:0] diff;
	logic [31:0] mag;
	logic [35:0] j_decay;
	logic        gap;

	always_comb begin
		delta   = seq - old_state.prev_seq;
		diff    = transit - old_state.prev_transit;
		mag     = diff[31] ? (32'd0 - diff) : diff;
		// j - j/16 does not wait on the transit difference
		j_decay = old_state.jitter - (old_state.jitter >> JIT_SHIFT);
		gap     = (delta > 16'd1) && (delta < SEQ_GAP_LIMIT);

		new_state              = old_state;
		new_state.packets      = old_state.packets + 32'd1;
		new_state.prev_seq     = seq;
		new_state.prev_transit = transit;
		if (!first) begin
			if (gap) begin
				new_state.lost = old_state.lost + {16'd0, delta - 16'd1};
			end
			new_state.jitter = j_decay + {4'd0, mag};
		end
	end

endmodule

/* src/rtp_relay_stats_router_top.sv */
// top level of the rtp relay statistics router
// a result beat is registered first in stage 1, then in the output register
// throughput: one header per cycle unless the output stalls; the per-direction entry is read,
//   updated and written back in a ram with forwarding between back-to-back beats of one direction
// reset: arst_n clears control state, configuration and latched ports at once;
//   the statistics ram is not cleared, per-direction seen bits make it read as zero
module rtp_relay_stats_router_top
	import rrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] source_address,
	input  logic [15:0] source_port,
	input  logic [1:0]  version_bits,
	input  logic [15:0] seq_num,
	input  logic [31:0] media_timestamp,
	input  logic [31:0] arrival_ms,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  verdict,
	output logic        forward,
	output logic [31:0] dest_address,
	output logic [15:0] dest_port,
	output logic [31:0] packets_seen,
	output logic [31:0] packets_lost,
	output logic [35:0] jitter_x16
);

	// configuration and latched media ports
	logic [31:0] caller_address_q;
	logic [31:0] callee_address_q;
	logic [15:0] caller_port_q;
	logic [15:0] callee_port_q;

	// per-direction first-packet tracking, lives in flops so reset is immediate
	logic [DIR_COUNT-1:0] seen_q;

	// stage 1: ram read data is valid here
	logic        s1_valid_q;
	logic [1:0]  verdict_s1;
	logic [15:0] sport_s1;
	logic [15:0] seq_s1;
	logic [31:0] transit_s1;
	logic        fwd_s1;
	dir_state_t  fwd_data_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  verdict_q;
	logic        forward_q;
	logic [31:0] dest_address_q;
	logic [15:0] dest_port_q;
	logic [31:0] packets_q;
	logic [31:0] lost_q;
	logic [35:0] jitter_q;

	logic                   in_accept;
	logic                   s1_adv;
	logic                   s1_known;
	logic                   s1_write;
	logic                   dir_s1;
	logic                   dir_in;
	logic [1:0]             verdict_in;
	logic [31:0]            transit_in;
	logic [DIR_STATE_W-1:0] rd_data;
	dir_state_t             old_state;
	dir_state_t             new_state;
	logic                   s1_first;

	// ---------------------------------------------------------------
	// handshake: stage 1 moves on whenever the output register is free
	// or being drained, so unless the output stalls a new beat enters every cycle
	// ---------------------------------------------------------------
	assign s1_adv    = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid_q && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// stage 0: classify the header and start the entry read
	// caller match wins when both addresses are equal
	// ---------------------------------------------------------------
	always_comb begin
		if (version_bits != VERSION_RTP) begin
			verdict_in = V_BAD;
		end else if (source_address == caller_address_q) begin
			verdict_in = V_CALLER;
		end else if (source_address == callee_address_q) begin
			verdict_in = V_CALLEE;
		end else begin
			verdict_in = V_UNKNOWN;
		end
	end

	assign dir_in     = (verdict_in == V_CALLEE);
	assign transit_in = arrival_ms - (media_timestamp >> TS_SHIFT);

	rrs_ram #(
		.WIDTH (DIR_STATE_W),
		.DEPTH (DIR_COUNT)
	) u_stats_ram (
		.clk   (clk),
		.we    (s1_write),
		.waddr (dir_s1),
		.wdata (new_state),
		.re    (in_accept),
		.raddr (dir_in),
		.rdata (rd_data)
	);

	// ---------------------------------------------------------------
	// stage 1: read-modify-write of the direction entry
	// ---------------------------------------------------------------
	assign dir_s1   = (verdict_s1 == V_CALLEE);
	assign s1_known = (verdict_s1 == V_CALLER) || (verdict_s1 == V_CALLEE);
	assign s1_write = s1_valid_q && s1_adv && s1_known;
	assign s1_first = !seen_q[dir_s1];

	// the previous beat's write lands on the same edge as this beat's read,
	// so its result is bypassed; an entry never written reads as zero
	always_comb begin
		if (fwd_s1) begin
			old_state = fwd_data_q;
		end else if (seen_q[dir_s1]) begin
			old_state = dir_state_t'(rd_data);
		end else begin
			old_state = '0;
		end
	end

	rrs_update u_update (
		.old_state (old_state),
		.first     (s1_first),
		.seq       (seq_s1),
		.transit   (transit_s1),
		.new_state (new_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
				fwd_s1     <= s1_write && (dir_s1 == dir_in);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
				fwd_s1     <= 1'b0;
			end
		end
	end

	// stage 1 payload and bypass data
	always_ff @(posedge clk) begin
		if (in_accept) begin
			verdict_s1 <= verdict_in;
			sport_s1   <= source_port;
			seq_s1     <= seq_num;
			transit_s1 <= transit_in;
			fwd_data_q <= new_state;
		end
	end

	// configuration, latched ports and seen bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caller_address_q <= '0;
			callee_address_q <= '0;
			caller_port_q    <= '0;
			callee_port_q    <= '0;
			seen_q           <= '0;
		end else begin
			if (s1_write) begin
				seen_q[dir_s1] <= 1'b1;
				if (dir_s1) begin
					callee_port_q <= sport_s1;
				end else begin
					caller_port_q <= sport_s1;
				end
			end
			// a port write also reloads the latched port, like new signalling
			if (cfg_we) begin
				case (cfg_index)
					CFG_CALLER_ADDR: caller_address_q <= cfg_data;
					CFG_CALLEE_ADDR: callee_address_q <= cfg_data;
					CFG_CALLER_PORT: caller_port_q    <= cfg_data[15:0];
					CFG_CALLEE_PORT: callee_port_q    <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// output register: decoupled from stage 1 so the input can still fill stage 1
	// while a finished beat waits
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (s1_valid_q && s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			verdict_q      <= verdict_s1;
			forward_q      <= 1'b0;
			dest_address_q <= '0;
			dest_port_q    <= '0;
			packets_q      <= '0;
			lost_q         <= '0;
			jitter_q       <= '0;
			if (s1_known) begin
				packets_q <= new_state.packets;
				lost_q    <= new_state.lost;
				jitter_q  <= new_state.jitter;
				// send to the peer only once its port is known
				if (dir_s1 && (caller_port_q != 16'd0)) begin
					forward_q      <= 1'b1;
					dest_address_q <= caller_address_q;
					dest_port_q    <= caller_port_q;
				end else if (!dir_s1 && (callee_port_q != 16'd0)) begin
					forward_q      <= 1'b1;
					dest_address_q <= callee_address_q;
					dest_port_q    <= callee_port_q;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign forward      = forward_q;
	assign dest_address = dest_address_q;
	assign dest_port    = dest_port_q;
	assign packets_seen = packets_q;
	assign packets_lost = lost_q;
	assign jitter_x16   = jitter_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------

	// an empty stage 1 never back-pressures the input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> !in_stall)
		else $error("input stalled with stage 1 empty");

	// a bypass only happens for a direction that has been written
	a_fwd_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && fwd_s1) |-> seen_q[dir_s1])
		else $error("bypass on a direction never written");

	// a forwarded beat always carries a nonzero peer port
	a_fwd_port: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && forward) |-> (dest_port != 16'd0))
		else $error("forward with zero destination port");

	// dropped packets carry no statistics
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((verdict == V_BAD) || (verdict == V_UNKNOWN)))
			|-> (!forward && (packets_seen == 32'd0)))
		else $error("dropped packet carries statistics");

	// a known beat leaving stage 1 marks its direction seen
	a_seen_set: assert property (@(posedge clk) disable iff (!arst_n)
		s1_write |=> seen_q[$past(dir_s1)])
		else $error("direction not marked after write-back");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the rtp relay statistics router: queued header driver, result monitor
`timescale 1ns / 1ps

module tb_top;
	import rrs_pkg::*;

	// overall cycle budget, far above the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	// length of the long receiver hold-off in the fill-up phase
	localparam int LONG_HOLD   = 300;

	// one received rtp header as the block sees it
	typedef struct packed {
		logic [31:0] src;
		logic [15:0] sport;
		logic [1:0]  ver;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [31:0] arr;
	} rtp_hdr_t;

	// one routing decision with the statistics of its direction
	typedef struct packed {
		logic [1:0]  verdict;
		logic        fwd;
		logic [31:0] daddr;
		logic [15:0] dport;
		logic [31:0] seen;
		logic [31:0] lost;
		logic [35:0] jit;
	} route_res_t;

	// dut ports, the inputs all known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_CALLER_ADDR;
	logic [31:0] cfg_data = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] source_address = 32'd0;
	logic [15:0] source_port = 16'd0;
	logic [1:0]  version_bits = 2'd0;
	logic [15:0] seq_num = 16'd0;
	logic [31:0] media_timestamp = 32'd0;
	logic [31:0] arrival_ms = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  verdict;
	logic        forward;
	logic [31:0] dest_address;
	logic [15:0] dest_port;
	logic [31:0] packets_seen;
	logic [31:0] packets_lost;
	logic [35:0] jitter_x16;

	// headers waiting for the driver and routing decisions waiting for the monitor
	rtp_hdr_t   pending_hdrs [$];
	route_res_t routes_due [$];

	// predictor copy of the relay: configuration, latched ports, per-direction stats
	logic [31:0] relay_caller_addr;
	logic [31:0] relay_callee_addr;
	logic [15:0] caller_port_live;
	logic [15:0] callee_port_live;
	dir_state_t  dir_stats [DIR_COUNT];
	logic        dir_fresh [DIR_COUNT];

	// media stream generators, one per direction
	logic [15:0] gen_seq [DIR_COUNT];
	logic [31:0] gen_ts [DIR_COUNT];
	logic [31:0] gen_arr [DIR_COUNT];
	logic [15:0] gen_port [DIR_COUNT];

	// idling controls, set per phase
	int unsigned send_pct = 0;
	int unsigned recv_pct = 0;
	logic        hold_req = 1'b0;
	logic        recv_hold = 1'b0;

	// bookkeeping
	int err_count = 0;
	int results_checked = 0;
	int hdrs_queued = 0;
	int cfg_writes = 0;
	int cycle_count = 0;
	int verdict_seen [4];

	rtp_relay_stats_router_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.source_address  (source_address),
		.source_port     (source_port),
		.version_bits    (version_bits),
		.seq_num         (seq_num),
		.media_timestamp (media_timestamp),
		.arrival_ms      (arrival_ms),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.verdict         (verdict),
		.forward         (forward),
		.dest_address    (dest_address),
		.dest_port       (dest_port),
		.packets_seen    (packets_seen),
		.packets_lost    (packets_lost),
		.jitter_x16      (jitter_x16)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: timeout after %0d cycles", cycle_count);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// predictor: classify one header, update the direction it belongs to,
	// and work out the result beat the block must give for it
	task automatic route_packet(input rtp_hdr_t h, output route_res_t r);
		logic [31:0] transit;
		logic [31:0] diff;
		logic [31:0] mag;
		logic [15:0] delta;
		logic [35:0] jit;
		int dir;
		r = '0;
		if (h.ver != VERSION_RTP) begin
			r.verdict = V_BAD;
		end else if (h.src != relay_caller_addr && h.src != relay_callee_addr) begin
			r.verdict = V_UNKNOWN;
		end else begin
			// caller match wins when both addresses are the same
			dir = (h.src == relay_caller_addr) ? 0 : 1;
			transit = h.arr - (h.ts >> TS_SHIFT);
			dir_stats[dir].packets = dir_stats[dir].packets + 32'd1;
			if (!dir_fresh[dir]) begin
				delta = h.seq - dir_stats[dir].prev_seq;
				diff = transit - dir_stats[dir].prev_transit;
				// only modest forward gaps count as loss
				if (delta > 16'd1 && delta < SEQ_GAP_LIMIT)
					dir_stats[dir].lost = dir_stats[dir].lost + {16'd0, delta - 16'd1};
				// magnitude of the signed transit difference, 2^31 stays 2^31
				mag = diff[31] ? (32'd0 - diff) : diff;
				jit = dir_stats[dir].jitter;
				dir_stats[dir].jitter = jit + {4'd0, mag} - (jit >> JIT_SHIFT);
			end
			dir_stats[dir].prev_seq = h.seq;
			dir_stats[dir].prev_transit = transit;
			dir_fresh[dir] = 1'b0;
			if (dir == 0) begin
				r.verdict = V_CALLER;
				caller_port_live = h.sport;
				if (callee_port_live != 16'd0) begin
					r.fwd = 1'b1;
					r.daddr = relay_callee_addr;
					r.dport = callee_port_live;
				end
			end else begin
				r.verdict = V_CALLEE;
				callee_port_live = h.sport;
				if (caller_port_live != 16'd0) begin
					r.fwd = 1'b1;
					r.daddr = relay_caller_addr;
					r.dport = caller_port_live;
				end
			end
			r.seen = dir_stats[dir].packets;
			r.lost = dir_stats[dir].lost;
			r.jit = dir_stats[dir].jitter;
		end
	endtask

	// driver: on an accepted beat, predict and retire the header; then offer
	// the next one unless the sender idles. a stalled beat is held as is
	always @(posedge clk) begin : drive_hdrs
		route_res_t res;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				route_packet(pending_hdrs[0], res);
				routes_due.push_back(res);
				void'(pending_hdrs.pop_front());
			end
			if (in_valid && in_stall) begin
				// hold the stalled beat
			end else if (pending_hdrs.size() != 0 && $urandom_range(99) >= send_pct) begin
				source_address  <= pending_hdrs[0].src;
				source_port     <= pending_hdrs[0].sport;
				version_bits    <= pending_hdrs[0].ver;
				seq_num         <= pending_hdrs[0].seq;
				media_timestamp <= pending_hdrs[0].ts;
				arrival_ms      <= pending_hdrs[0].arr;
				in_valid        <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// field compare, only the first few mismatches are printed
	task automatic check_field(input string fname, input logic [35:0] want,
			input logic [35:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= 10)
				$display("tb_top: result %0d field %s expected %h got %h",
					results_checked, fname, want, got);
		end
	endtask

	// monitor: every accepted result beat against the oldest prediction
	always @(posedge clk) begin : watch_results
		route_res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (routes_due.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("tb_top: result beat with nothing predicted, verdict %0d",
							verdict);
				end else begin
					want = routes_due.pop_front();
					results_checked++;
					check_field("verdict", want.verdict, verdict);
					check_field("forward", want.fwd, forward);
					check_field("dest_address", want.daddr, dest_address);
					check_field("dest_port", want.dport, dest_port);
					check_field("packets_seen", want.seen, packets_seen);
					check_field("packets_lost", want.lost, packets_lost);
					check_field("jitter_x16", want.jit, jitter_x16);
					verdict_seen[want.verdict]++;
				end
			end
			out_stall <= recv_hold || ($urandom_range(99) < recv_pct);
		end
	end

	// long receiver hold-off, counted here, so the block backs up into its input
	initial begin
		wait (hold_req);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		recv_hold <= 1'b0;
	end

	// register write on the plain write port, mirrored into the predictor
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_CALLER_ADDR: relay_caller_addr = val;
			CFG_CALLEE_ADDR: relay_callee_addr = val;
			// a port start write also reloads the latched port
			CFG_CALLER_PORT: caller_port_live = val[15:0];
			CFG_CALLEE_PORT: callee_port_live = val[15:0];
			default: ;
		endcase
	endtask

	// all four relay registers; junk in the unused upper bits of port writes
	task automatic set_relay(input logic [31:0] caller_a, input logic [31:0] callee_a,
			input logic [15:0] caller_p, input logic [15:0] callee_p);
		write_reg(CFG_CALLER_ADDR, caller_a);
		write_reg(CFG_CALLEE_ADDR, callee_a);
		write_reg(CFG_CALLER_PORT, {16'($urandom), caller_p});
		write_reg(CFG_CALLEE_PORT, {16'($urandom), callee_p});
	endtask

	// sender pauses until every predicted result has come back
	task automatic wait_drained();
		while (pending_hdrs.size() != 0 || in_valid || routes_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic rtp_hdr_t mk_hdr(input logic [31:0] src, input logic [15:0] sport,
			input logic [1:0] ver, input logic [15:0] seq, input logic [31:0] ts,
			input logic [31:0] arr);
		rtp_hdr_t h;
		h.src = src;
		h.sport = sport;
		h.ver = ver;
		h.seq = seq;
		h.ts = ts;
		h.arr = arr;
		return h;
	endfunction

	// next packet of a plausible media stream in one direction
	function automatic rtp_hdr_t stream_hdr(input int d);
		rtp_hdr_t h;
		int pick;
		pick = $urandom_range(99);
		// mostly in order, some losses, gaps around the loss limit, repeats, wild jumps
		if (pick < 78)
			gen_seq[d] = gen_seq[d] + 16'd1;
		else if (pick < 87)
			gen_seq[d] = gen_seq[d] + 16'($urandom_range(2, 20));
		else if (pick < 91)
			gen_seq[d] = gen_seq[d] + 16'($urandom_range(2990, 3010));
		else if (pick < 94)
			gen_seq[d] = gen_seq[d];
		else
			gen_seq[d] = 16'($urandom);
		// 160 timestamp ticks per 20 ms, with the odd reset of the clock
		if ($urandom_range(99) < 95)
			gen_ts[d] = gen_ts[d] + 32'd160;
		else
			gen_ts[d] = $urandom;
		if ($urandom_range(99) < 95)
			gen_arr[d] = gen_arr[d] + 32'($urandom_range(5, 40));
		else
			gen_arr[d] = $urandom;
		// occasional port change, sometimes to zero
		if ($urandom_range(99) < 6)
			gen_port[d] = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
		h.src = (d == 0) ? relay_caller_addr : relay_callee_addr;
		h.sport = gen_port[d];
		h.ver = VERSION_RTP;
		h.seq = gen_seq[d];
		h.ts = gen_ts[d];
		h.arr = gen_arr[d];
		return h;
	endfunction

	// mostly well-formed streams, then bad versions, strangers and raw noise
	function automatic rtp_hdr_t random_hdr();
		rtp_hdr_t h;
		int pick;
		logic [1:0] v;
		pick = $urandom_range(99);
		if (pick < 42) begin
			h = stream_hdr(0);
		end else if (pick < 84) begin
			h = stream_hdr(1);
		end else if (pick < 90) begin
			h = stream_hdr($urandom_range(1));
			v = 2'($urandom_range(2));
			h.ver = (v == VERSION_RTP) ? 2'd3 : v;
		end else if (pick < 95) begin
			h.src = $urandom;
			h.seq = 16'($urandom);
			h.ts = $urandom;
			h.arr = $urandom;
			h.sport = 16'($urandom);
			h.ver = VERSION_RTP;
		end else begin
			h.src = $urandom;
			h.sport = 16'($urandom);
			h.ver = 2'($urandom);
			h.seq = 16'($urandom);
			h.ts = $urandom;
			h.arr = $urandom;
		end
		return h;
	endfunction

	// queue one phase of random headers under given idling, then drain
	task automatic run_phase(input int n, input int unsigned sp, input int unsigned rp);
		send_pct = sp;
		recv_pct = rp;
		repeat (n) begin
			pending_hdrs.push_back(random_hdr());
			hdrs_queued++;
		end
		wait_drained();
	endtask

	task automatic queue_hdr(input rtp_hdr_t h);
		pending_hdrs.push_back(h);
		hdrs_queued++;
	endtask

	initial begin : stimulus
		logic [31:0] same_addr;
		// predictor state as after reset
		relay_caller_addr = 32'd0;
		relay_callee_addr = 32'd0;
		caller_port_live = 16'd0;
		callee_port_live = 16'd0;
		for (int i = 0; i < DIR_COUNT; i++) begin
			dir_stats[i] = '0;
			dir_fresh[i] = 1'b1;
			gen_seq[i] = 16'($urandom);
			gen_ts[i] = $urandom;
			gen_arr[i] = $urandom;
			gen_port[i] = 16'($urandom_range(1024, 65535));
		end
		for (int i = 0; i < 4; i++)
			verdict_seen[i] = 0;

		// reset held from time zero, released once
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset configuration, both addresses zero, both ports zero
		// first packet of a direction, caller wins over callee, no peer port
		queue_hdr(mk_hdr(32'd0, 16'd0, VERSION_RTP, 16'd0, 32'd0, 32'd0));
		queue_hdr(mk_hdr(32'd0, 16'h1234, VERSION_RTP, 16'd1, 32'd8, 32'd1));
		queue_hdr(mk_hdr(32'd1, 16'd5, VERSION_RTP, 16'd7, 32'd0, 32'd0));
		queue_hdr(mk_hdr(32'd0, 16'd5, 2'd0, 16'd2, 32'd16, 32'd2));
		wait_drained();

		// directed: extreme addresses and ports
		set_relay(32'h0A00_0001, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
		// bad versions from known sources, a stranger at address zero
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, 2'd1, 16'd3, 32'd0, 32'd0));
		queue_hdr(mk_hdr(32'hFFFF_FFFF, 16'hFFFF, 2'd3, 16'd3, 32'd0, 32'd0));
		queue_hdr(mk_hdr(32'd0, 16'hFFFF, VERSION_RTP, 16'd3, 32'd0, 32'd0));
		// field extremes, then sequence wrap, loss of one, largest counted gap,
		// gap at the limit, repeat and step back
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd0, 32'hFFFF_FFFF, 32'd0));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd2, 32'd160, 32'd20));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd3001, 32'd320, 32'd40));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd6001, 32'd480, 32'd60));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd6001, 32'd640, 32'd80));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd6000, 32'd800, 32'd100));
		// transit jumps of exactly half the range, both ways
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd6001, 32'd0, 32'd0));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd6002, 32'd0,
			32'h8000_0000));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd6003, 32'd0, 32'd0));
		// callee with source port zero: forwarded to caller, then caller sees no peer port
		queue_hdr(mk_hdr(32'hFFFF_FFFF, 16'd0, VERSION_RTP, 16'h8000, 32'd0, 32'd0));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd6004, 32'd0, 32'd20));
		queue_hdr(mk_hdr(32'hFFFF_FFFF, 16'h8000, VERSION_RTP, 16'h8001, 32'd160, 32'd20));
		queue_hdr(mk_hdr(32'h0A00_0001, 16'hFFFF, VERSION_RTP, 16'd6005, 32'd160, 32'd40));
		wait_drained();

		// random phases, a new relay setting before each
		set_relay($urandom, $urandom, 16'd5004, 16'd6000);
		run_phase(110, 0, 0);

		set_relay(32'hFFFF_FFFF, 32'd0, 16'd0, 16'hFFFF);
		run_phase(110, 70, 0);

		// caller and callee at one address: everything known goes caller side
		same_addr = $urandom;
		set_relay(same_addr, same_addr, 16'hFFFF, 16'd0);
		run_phase(100, 0, 70);

		set_relay($urandom, $urandom, 16'($urandom), 16'($urandom));
		run_phase(110, 12, 12);

		// fill-up: receiver holds off for a long stretch while the sender keeps going
		set_relay(32'd0, $urandom, 16'($urandom), 16'hFFFF);
		hold_req = 1'b1;
		run_phase(40, 0, 0);

		// let any late beat show up before the verdict
		repeat (20) @(posedge clk);
		if (routes_due.size() != 0) begin
			err_count++;
			$display("tb_top: %0d predicted results never arrived", routes_due.size());
		end

		$display("tb_top: %0d headers, %0d results checked, %0d register writes",
			hdrs_queued, results_checked, cfg_writes);
		$display("tb_top: verdicts bad %0d unknown %0d caller %0d callee %0d, %0d mismatches",
			verdict_seen[V_BAD], verdict_seen[V_UNKNOWN], verdict_seen[V_CALLER],
			verdict_seen[V_CALLEE], err_count);
		if (err_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
src/rrs_pkg.sv
src/rrs_ram.sv
src/rrs_update.sv
src/rtp_relay_stats_router_top.sv
tb/tb_top.sv
